FILE: rtl/core/mwpihd_pkg.sv
`timescale 1ns / 1ps

package mwpihd_pkg;

   // integral store depth, one entry per motion code
   localparam int NUM_MOTIONS = 11;
   localparam int MOT_IDX_W   = $clog2(NUM_MOTIONS);
   localparam int MOT_CODES   = 11;

   // channel payload widths
   localparam int WHEEL_W   = 2;
   localparam int MOTION_W  = 4;
   localparam int SPEED_W   = 16;
   localparam int HEADING_W = 16;
   localparam int CHAN_W    = 4;
   localparam int PULSE_W   = 12;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_INT_GAIN         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INTEGRAL_LIMIT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CORRECTION_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_NOMINAL     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE_MIN        = 3'd5;

   localparam logic [15:0] RST_INT_GAIN         = 16'd256;
   localparam logic [15:0] RST_PROP_GAIN        = 16'd256;
   localparam logic [9:0]  RST_INTEGRAL_LIMIT   = 10'd20;
   localparam logic [9:0]  RST_CORRECTION_LIMIT = 10'd20;
   localparam logic [11:0] RST_STOP_NOMINAL     = 12'd1500;
   localparam logic [7:0]  RST_DRIVE_MIN        = 8'd40;

   // motion codes with a heading correction
   localparam logic [MOTION_W-1:0] MOT_FWD        = 4'd1;
   localparam logic [MOTION_W-1:0] MOT_TRANS_LAST = 4'd8;

   // datapath widths
   localparam int INTEG_W = 27;   // clamped signed Q10.16 values, limit at most 1023
   localparam int SUM_W   = 35;   // stored integral plus gain product
   localparam int MUL_A_W = 27;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int K_W     = 10;   // polarity * direction * drive_min
   localparam int STOP_W  = 13;
   localparam int BASE_W  = 29;
   localparam int Q14     = 14;
   localparam int DRV_W   = BASE_W - Q14;
   localparam int Q30     = 30;
   localparam int FIN_W   = 46;
   localparam int QOUT_W  = FIN_W - Q30;

   typedef struct packed {
      logic [15:0] int_gain;
      logic [15:0] prop_gain;
      logic [9:0]  integral_limit;
      logic [9:0]  correction_limit;
      logic [11:0] stop_nominal;
      logic [7:0]  drive_min;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_IGAIN,
      ST_PGAIN,
      ST_BASE,
      ST_TERM,
      ST_FINAL
   } state_type;

   typedef enum logic [1:0] {
      MUL_IGAIN,
      MUL_PGAIN,
      MUL_BASE,
      MUL_TERM
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        integ_en;
      logic        corr_en;
      logic        drv_en;
      logic        final_en;
   } dp_cmd_type;

   typedef struct packed {
      logic out_stall;
   } dp_status_type;

   // polarity times direction, per wheel and motion
   localparam logic signed [2:0] PD_ROM [4][MOT_CODES] = '{
      '{3'sd0,  3'sd1, -3'sd1,  3'sd1, -3'sd1,  3'sd2,  3'sd0,  3'sd0, -3'sd2,  3'sd1, -3'sd1},
      '{3'sd0, -3'sd1,  3'sd1,  3'sd1, -3'sd1,  3'sd0, -3'sd2,  3'sd2,  3'sd0,  3'sd1, -3'sd1},
      '{3'sd0,  3'sd1, -3'sd1, -3'sd1,  3'sd1,  3'sd0,  3'sd2, -3'sd2,  3'sd0,  3'sd1, -3'sd1},
      '{3'sd0, -3'sd1,  3'sd1, -3'sd1,  3'sd1, -3'sd2,  3'sd0,  3'sd0,  3'sd2,  3'sd1, -3'sd1}
   };

   function automatic logic signed [2:0] pd_lookup(input logic [WHEEL_W-1:0] wheel,
                                                   input logic [MOTION_W-1:0] motion);
      logic signed [2:0] pd;
      pd = 3'sd0;
      if (motion < MOTION_W'(MOT_CODES)) begin
         pd = PD_ROM[wheel][motion];
      end
      return pd;
   endfunction

   function automatic logic [CHAN_W-1:0] chan_lookup(input logic [WHEEL_W-1:0] wheel);
      logic [CHAN_W-1:0] chan;
      unique case (wheel)
         2'd0:    chan = 4'd1;
         2'd1:    chan = 4'd5;
         2'd2:    chan = 4'd0;
         default: chan = 4'd4;
      endcase
      return chan;
   endfunction

   function automatic logic [4:0] trim_lookup(input logic [WHEEL_W-1:0] wheel);
      logic [4:0] trim;
      unique case (wheel)
         2'd0:    trim = 5'd15;
         2'd1:    trim = 5'd25;
         2'd2:    trim = 5'd20;
         default: trim = 5'd15;
      endcase
      return trim;
   endfunction

   function automatic logic signed [SUM_W-1:0] clamp_sym(input logic signed [SUM_W-1:0] v,
                                                         input logic signed [SUM_W-1:0] lim);
      logic signed [SUM_W-1:0] r;
      if (v > lim) begin
         r = lim;
      end else if (v < -lim) begin
         r = -lim;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/mwpihd_if.sv
`timescale 1ns / 1ps

interface mwpihd_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         wheel;
   logic [3:0]         motion;
   logic signed [15:0] speed;
   logic signed [15:0] heading;

   modport source (output valid, output wheel, output motion, output speed,
                   output heading, input ready);
   modport sink (input valid, input wheel, input motion, input speed,
                 input heading, output ready);
endinterface

interface mwpihd_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  channel;
   logic [11:0] pulse;

   modport source (output valid, output channel, output pulse, input ready);
   modport sink (input valid, input channel, input pulse, output ready);
endinterface

interface mwpihd_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/mwpihd_regs.sv
`timescale 1ns / 1ps

module mwpihd_regs (
   input  logic                clock,
   input  logic                reset,
   mwpihd_csr_if.sink          csr,
   output mwpihd_pkg::cfg_type cfg
);
   import mwpihd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr.ready = !reset;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            REG_INT_GAIN:         cfg_in.int_gain         = csr.data;
            REG_PROP_GAIN:        cfg_in.prop_gain        = csr.data;
            REG_INTEGRAL_LIMIT:   cfg_in.integral_limit   = csr.data[9:0];
            REG_CORRECTION_LIMIT: cfg_in.correction_limit = csr.data[9:0];
            REG_STOP_NOMINAL:     cfg_in.stop_nominal     = csr.data[11:0];
            REG_DRIVE_MIN:        cfg_in.drive_min        = csr.data[7:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.int_gain         <= RST_INT_GAIN;
         cfg_ff.prop_gain        <= RST_PROP_GAIN;
         cfg_ff.integral_limit   <= RST_INTEGRAL_LIMIT;
         cfg_ff.correction_limit <= RST_CORRECTION_LIMIT;
         cfg_ff.stop_nominal     <= RST_STOP_NOMINAL;
         cfg_ff.drive_min        <= RST_DRIVE_MIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/core/mwpihd_ctrl.sv
`timescale 1ns / 1ps

module mwpihd_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  mwpihd_pkg::dp_status_type sts,
   output mwpihd_pkg::dp_cmd_type    cmd
);
   import mwpihd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.mul_sel = MUL_IGAIN;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = ST_IGAIN;
            end
         end
         ST_IGAIN: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_IGAIN;
            state_in    = ST_PGAIN;
         end
         ST_PGAIN: begin
            cmd.integ_en = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_PGAIN;
            state_in     = ST_BASE;
         end
         ST_BASE: begin
            cmd.corr_en = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_BASE;
            state_in    = ST_TERM;
         end
         ST_TERM: begin
            cmd.drv_en  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_TERM;
            state_in    = ST_FINAL;
         end
         ST_FINAL: begin
            // wait for the result register to free up
            if (!sts.out_stall) begin
               cmd.final_en = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_IGAIN)
      else $error("accepted transaction did not start the sequence");

   a_corr_then_drv: assert property (@(posedge clock) disable iff (reset)
      cmd.corr_en |=> cmd.drv_en && cmd.mul_sel == MUL_TERM)
      else $error("correction step not followed by term product");

   a_final_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINAL && sts.out_stall) |=> state_ff == ST_FINAL)
      else $error("left final step while result register busy");

endmodule

FILE: rtl/core/mwpihd_dp.sv
`timescale 1ns / 1ps

module mwpihd_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  mwpihd_pkg::cfg_type       cfg,
   input  mwpihd_pkg::dp_cmd_type    cmd,
   output mwpihd_pkg::dp_status_type sts,
   input  logic [1:0]                req_wheel,
   input  logic [3:0]                req_motion,
   input  logic signed [15:0]        req_speed,
   input  logic signed [15:0]        req_heading,
   mwpihd_rsp_if.source              rsp
);
   import mwpihd_pkg::*;

   localparam logic signed [INTEG_W-1:0] INTEG_MAX = INTEG_W'({10'h3ff, 16'h0000});
   localparam logic signed [QOUT_W-1:0]  PULSE_MAX = QOUT_W'(12'hfff);

   // latched transaction
   logic [WHEEL_W-1:0]          wheel_ff;
   logic [MOTION_W-1:0]         motion_ff;
   logic signed [SPEED_W-1:0]   speed_ff;
   logic signed [HEADING_W-1:0] heading_ff;
   logic signed [K_W-1:0]       k_ff;
   logic signed [K_W-1:0]       k_in;
   logic                        trans_ff;
   logic                        trans_in;

   // working registers
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [INTEG_W-1:0] integ_ff;
   logic signed [INTEG_W-1:0] integ_in;
   logic signed [INTEG_W-1:0] corr_ff;
   logic signed [INTEG_W-1:0] corr_in;
   logic signed [DRV_W-1:0]   drv_ff;
   logic signed [DRV_W-1:0]   drv_in;
   logic signed [INTEG_W-1:0] mi_ff [NUM_MOTIONS];

   // result register
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [CHAN_W-1:0]   rsp_chan_ff;
   logic [PULSE_W-1:0]  rsp_pulse_ff;
   logic [PULSE_W-1:0]  pulse_in;

   logic signed [2:0]         pd;
   logic [8:0]                k_mag;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [INTEG_W-1:0] mi_rd;
   logic signed [SUM_W-1:0]   ilim;
   logic signed [SUM_W-1:0]   clim;
   logic signed [SUM_W-1:0]   isum;
   logic signed [SUM_W-1:0]   csum;
   logic signed [SUM_W-1:0]   iclamp;
   logic signed [SUM_W-1:0]   cclamp;
   logic [STOP_W-1:0]         stop_val;
   logic signed [BASE_W-1:0]  nb;
   logic                      nb_rnd;
   logic signed [FIN_W-1:0]   fsum;
   logic                      f_rnd;
   logic signed [QOUT_W-1:0]  q_trans;
   logic signed [QOUT_W-1:0]  q;

   // load: speed scale from polarity, direction and drive span
   always_comb begin
      pd = pd_lookup(req_wheel, req_motion);
      if (pd == 3'sd2 || pd == -3'sd2) begin
         k_mag = {cfg.drive_min, 1'b0};
      end else if (pd != 3'sd0) begin
         k_mag = {1'b0, cfg.drive_min};
      end else begin
         k_mag = '0;
      end
      k_in     = pd[2] ? -K_W'(k_mag) : K_W'(k_mag);
      trans_in = (req_motion >= MOT_FWD) && (req_motion <= MOT_TRANS_LAST);
   end

   // shared multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         MUL_IGAIN: begin
            mul_a = MUL_A_W'(heading_ff);
            mul_b = $signed({1'b0, cfg.int_gain});
         end
         MUL_PGAIN: begin
            mul_a = MUL_A_W'(heading_ff);
            mul_b = $signed({1'b0, cfg.prop_gain});
         end
         MUL_BASE: begin
            mul_a = MUL_A_W'(speed_ff);
            mul_b = MUL_B_W'(k_ff);
         end
         MUL_TERM: begin
            mul_a = corr_ff;
            mul_b = MUL_B_W'(speed_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // integral and correction clamps
   always_comb begin
      // codes past the store have no entry and no correction
      mi_rd = '0;
      if (motion_ff < MOTION_W'(NUM_MOTIONS)) begin
         mi_rd = mi_ff[motion_ff[MOT_IDX_W-1:0]];
      end
      ilim     = SUM_W'({cfg.integral_limit, 16'h0000});
      clim     = SUM_W'({cfg.correction_limit, 16'h0000});
      isum     = SUM_W'(mi_rd) + $signed(prod_ff[SUM_W-1:0]);
      iclamp   = clamp_sym(isum, ilim);
      integ_in = iclamp[INTEG_W-1:0];
      csum     = $signed(prod_ff[SUM_W-1:0]) + SUM_W'(integ_ff);
      cclamp   = clamp_sym(csum, clim);
      corr_in  = cclamp[INTEG_W-1:0];
   end

   // base pulse, q14 truncated toward zero
   always_comb begin
      stop_val = {1'b0, cfg.stop_nominal} + STOP_W'(trim_lookup(wheel_ff));
      nb       = BASE_W'($signed({1'b0, stop_val, {Q14{1'b0}}}))
                 + $signed(prod_ff[BASE_W-1:0]);
      nb_rnd   = nb[BASE_W-1] && (nb[Q14-1:0] != '0);
      drv_in   = $signed(nb[BASE_W-1:Q14]) + $signed({{(DRV_W-1){1'b0}}, nb_rnd});
   end

   // final sum, q30 truncated toward zero, then saturate
   always_comb begin
      fsum    = FIN_W'($signed({drv_ff, {Q30{1'b0}}})) + FIN_W'(prod_ff);
      f_rnd   = fsum[FIN_W-1] && (fsum[Q30-1:0] != '0);
      q_trans = $signed(fsum[FIN_W-1:Q30]) + $signed({{(QOUT_W-1){1'b0}}, f_rnd});
      q       = trans_ff ? q_trans : QOUT_W'(drv_ff);
      if (q[QOUT_W-1]) begin
         pulse_in = '0;
      end else if (q > PULSE_MAX) begin
         pulse_in = '1;
      end else begin
         pulse_in = q[PULSE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         wheel_ff   <= req_wheel;
         motion_ff  <= req_motion;
         speed_ff   <= req_speed;
         heading_ff <= req_heading;
         k_ff       <= k_in;
         trans_ff   <= trans_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.integ_en) begin
         integ_ff <= integ_in;
      end
      if (cmd.corr_en) begin
         corr_ff <= corr_in;
      end
      if (cmd.drv_en) begin
         drv_ff <= drv_in;
      end
      if (cmd.final_en) begin
         rsp_chan_ff  <= chan_lookup(wheel_ff);
         rsp_pulse_ff <= pulse_in;
      end
   end

   // per-motion integral store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_MOTIONS; i++) begin
            mi_ff[i] <= '0;
         end
      end else if (cmd.corr_en && trans_ff) begin
         mi_ff[motion_ff[MOT_IDX_W-1:0]] <= integ_ff;
      end
   end

   always_comb begin
      if (cmd.final_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.out_stall = rsp_valid_ff && !rsp.ready;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.channel   = rsp_chan_ff;
   assign rsp.pulse     = rsp_pulse_ff;

   a_integ_bounded: assert property (@(posedge clock) disable iff (reset)
      (cmd.corr_en && trans_ff) |-> (integ_ff <= INTEG_MAX && integ_ff >= -INTEG_MAX))
      else $error("integral written outside its largest clamp");

   a_corr_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.corr_en |=> (SUM_W'(corr_ff) <= $past(clim) && SUM_W'(corr_ff) >= -$past(clim)))
      else $error("correction outside its clamp");

   a_final_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.final_en |=> rsp_valid_ff)
      else $error("result register not valid after final step");

endmodule

FILE: rtl/core/mecanum_wheel_pi_heading_drive.sv
`timescale 1ns / 1ps

// mecanum wheel servo drive with a pi heading correction; each req transaction
// (wheel, motion, speed, heading) yields exactly one rsp transaction (channel,
// pulse); the pulse is stop_nominal plus the wheel trim plus the speed-scaled
// drive span, and for the translating motion codes one through eight a
// per-motion clamped integral plus a proportional term, clamped and scaled by
// speed, is added; pulses saturate to 0..4095; req takes no new transaction
// until the last one is in the result register, as the single shared 27x17
// multiplier forms the four products (integral gain, proportional gain, base
// span, correction times speed) one after another; req is accepted again as
// soon as the result is in its register, so a result waiting on rsp does not
// stall the next transaction unless a second result is ready before the first
// is taken; the integral store is cleared by reset; configuration is written
// through csr at any index, indexes past drive_min are ignored; req and csr
// are not ready while reset is high
module mecanum_wheel_pi_heading_drive (
   input  logic        clock,
   input  logic        reset,
   mwpihd_req_if.sink  req_ch,
   mwpihd_rsp_if.source rsp_ch,
   mwpihd_csr_if.sink  csr_ch
);
   import mwpihd_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type sts;

   // configuration registers
   mwpihd_regs u_regs (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .cfg   (cfg)
   );

   // sequencer: accept, four multiplies, result write
   mwpihd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // shared multiplier, clamps, integral store and result register
   mwpihd_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .sts         (sts),
      .req_wheel   (req_ch.wheel),
      .req_motion  (req_ch.motion),
      .req_speed   (req_ch.speed),
      .req_heading (req_ch.heading),
      .rsp         (rsp_ch)
   );

endmodule
